[rtl/rxd_pkg.sv]
// Shared types and constants for the rotate-XOR packet descrambler.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package rxd_pkg;

   localparam int WINDOW_BYTES = 8;
   localparam int BYTE_W       = 8;
   localparam int KEY_LEN_W    = 6;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_WORD0 = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_LEN   = 3'd4;
   localparam logic [KEY_LEN_W-1:0]  KEY_LEN_RESET = 6'd16;

   // Item class assigned by the front end.
   typedef enum logic [1:0] {
      KIND_HDR0,
      KIND_HDR1,
      KIND_DATA
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_MISMATCH = 2'd1,
      STATUS_SHORT    = 2'd2
   } status_type;

   typedef struct packed {
      kind_type            kind;
      logic [BYTE_W-1:0]   data;
      logic                last;
   } entry_type;

endpackage

[rtl/rxd_front.sv]
// Front end: accepts input items and tags each as first header, second header or payload.
// Depends on rxd_pkg; feeds rxd_queue.
module rxd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] cipher_byte
   input  logic                      req_tlast,
   input  logic                      queue_full,
   output logic                      push,
   output rxd_pkg::entry_type        push_entry
);

   rxd_pkg::kind_type phase_ff, phase_in;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   assign push_entry.kind = phase_ff;
   assign push_entry.data = req_tdata;
   assign push_entry.last = req_tlast;

   always_comb begin
      phase_in = phase_ff;
      if (push) begin
         if (req_tlast) begin
            phase_in = rxd_pkg::KIND_HDR0;
         end else begin
            case (phase_ff)
               rxd_pkg::KIND_HDR0: phase_in = rxd_pkg::KIND_HDR1;
               rxd_pkg::KIND_HDR1: phase_in = rxd_pkg::KIND_DATA;
               rxd_pkg::KIND_DATA: phase_in = rxd_pkg::KIND_DATA;
               default:            phase_in = rxd_pkg::KIND_HDR0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rxd_pkg::KIND_HDR0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

[rtl/rxd_queue.sv]
// Short FIFO of tagged items between the front end and the back end.
// Depends on rxd_pkg.
module rxd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rxd_pkg::entry_type   push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output rxd_pkg::entry_type   head
);

   localparam int PTR_W = $clog2(rxd_pkg::QUEUE_DEPTH);

   rxd_pkg::entry_type entry_ff [rxd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign full       = (count_ff == (PTR_W+1)'(rxd_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/rxd_back.sv]
// Back end: header decode, XOR/rotate of payload, running checksum and the result register.
// Also holds the key registers. Depends on rxd_pkg; drains rxd_queue.
module rxd_back #(
   parameter int MAX_KEY_BYTES = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rxd_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [rxd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              q_valid,
   input  rxd_pkg::entry_type                q_head,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_byte,
   output logic                              rsp_last,
   output rxd_pkg::status_type               rsp_status
);

   localparam int KIDX_W  = $clog2(MAX_KEY_BYTES);
   localparam int DIV_W   = $clog2(MAX_KEY_BYTES - rxd_pkg::WINDOW_BYTES + 1);
   localparam int PHASE_W = $clog2(rxd_pkg::WINDOW_BYTES);
   localparam int TRAIL   = 4;
   localparam int CNT_W   = $clog2(TRAIL + 1);
   localparam int SUM_W   = 32;

   typedef enum logic {ST_RUN, ST_DIV} state_type;

   state_type                        state_ff, state_in;
   logic [2:0]                       rot_ff, rot_in;
   logic [KIDX_W-1:0]                window_ff, window_in;
   logic [PHASE_W-1:0]               phase_ff, phase_in;
   logic [SUM_W-1:0]                 sum_ff, sum_in;
   logic [7:0]                       trail_ff [TRAIL];
   logic [7:0]                       trail_in [TRAIL];
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [7:0]                       div_dvd_ff, div_dvd_in;
   logic [DIV_W-1:0]                 div_dvs_ff, div_dvs_in;
   logic [DIV_W-1:0]                 div_rem_ff, div_rem_in;
   logic [2:0]                       div_step_ff, div_step_in;
   logic [7:0]                       key_ff [MAX_KEY_BYTES];
   logic [7:0]                       key_in [MAX_KEY_BYTES];
   logic [rxd_pkg::KEY_LEN_W-1:0]    key_len_ff, key_len_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [7:0]                       rsp_byte_ff, rsp_byte_in;
   logic                             rsp_last_ff, rsp_last_in;
   rxd_pkg::status_type              rsp_status_ff, rsp_status_in;

   logic                             out_free;
   logic [rxd_pkg::KEY_LEN_W-1:0]    klen_clamped;
   logic [DIV_W-1:0]                 divisor;
   logic [KIDX_W-1:0]                kidx;
   logic [7:0]                       plain;
   logic [SUM_W-1:0]                 sum_next;
   logic [CNT_W-1:0]                 count_next;
   logic [SUM_W-1:0]                 check;
   logic [DIV_W:0]                   trial;
   logic [DIV_W:0]                   trial_diff;
   logic [DIV_W-1:0]                 rem_next;

   // v mod 7 via reciprocal multiply; the estimate is low by at most one.
   function automatic logic [2:0] mod7(input logic [7:0] v);
      logic [13:0] prod;
      logic [7:0]  q;
      logic [7:0]  r;
      prod = 14'(v) * 14'd36;
      q    = 8'(prod >> 8);
      r    = v - (q * 8'd7);
      if (r >= 8'd7) begin
         r = r - 8'd7;
      end
      return r[2:0];
   endfunction

   function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] r);
      logic [15:0] dbl;
      dbl = {v, v} >> r;
      return dbl[7:0];
   endfunction

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_byte   = rsp_byte_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      klen_clamped = key_len_ff;
      if (key_len_ff < rxd_pkg::KEY_LEN_W'(rxd_pkg::WINDOW_BYTES + 1)) begin
         klen_clamped = rxd_pkg::KEY_LEN_W'(rxd_pkg::WINDOW_BYTES + 1);
      end else if (key_len_ff > rxd_pkg::KEY_LEN_W'(MAX_KEY_BYTES)) begin
         klen_clamped = rxd_pkg::KEY_LEN_W'(MAX_KEY_BYTES);
      end
   end

   assign divisor = DIV_W'(klen_clamped - rxd_pkg::KEY_LEN_W'(rxd_pkg::WINDOW_BYTES));

   // window start stays below the clamped key length minus 8, so the index never passes the key
   assign kidx       = window_ff + KIDX_W'(phase_ff);
   assign plain      = rotr8(q_head.data ^ key_ff[kidx], rot_ff);
   assign sum_next   = sum_ff + ((count_ff >= CNT_W'(TRAIL)) ? SUM_W'(trail_ff[0]) : '0);
   assign count_next = (count_ff < CNT_W'(TRAIL)) ? count_ff + 1'b1 : count_ff;
   assign check      = {plain, trail_ff[3], trail_ff[2], trail_ff[1]};

   // one restoring remainder step per cycle
   assign trial      = {div_rem_ff, div_dvd_ff[7]};
   assign trial_diff = trial - {1'b0, div_dvs_ff};
   assign rem_next   = (trial >= {1'b0, div_dvs_ff}) ? trial_diff[DIV_W-1:0]
                                                     : trial[DIV_W-1:0];

   always_comb begin
      state_in      = state_ff;
      rot_in        = rot_ff;
      window_in     = window_ff;
      phase_in      = phase_ff;
      sum_in        = sum_ff;
      trail_in      = trail_ff;
      count_in      = count_ff;
      div_dvd_in    = div_dvd_ff;
      div_dvs_in    = div_dvs_ff;
      div_rem_in    = div_rem_ff;
      div_step_in   = div_step_ff;
      key_in        = key_ff;
      key_len_in    = key_len_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      q_pop         = 1'b0;

      if (csr_we) begin
         for (int b = 0; b < MAX_KEY_BYTES; b++) begin
            if (csr_addr == rxd_pkg::CSR_KEY_WORD0 + rxd_pkg::CSR_ADDR_W'(b >> 3)) begin
               key_in[b] = csr_wdata[(b & 7) * 8 +: 8];
            end
         end
         if (csr_addr == rxd_pkg::CSR_KEY_LEN) begin
            key_len_in = csr_wdata[rxd_pkg::KEY_LEN_W-1:0];
         end
      end

      case (state_ff)
         ST_RUN: begin
            if (q_valid) begin
               case (q_head.kind)
                  rxd_pkg::KIND_HDR0: begin
                     if (!q_head.last) begin
                        q_pop  = 1'b1;
                        rot_in = mod7(q_head.data) + 3'd1;
                     end else if (out_free) begin
                        q_pop = 1'b1;
                     end
                  end
                  rxd_pkg::KIND_HDR1: begin
                     if (!q_head.last) begin
                        q_pop       = 1'b1;
                        div_dvd_in  = q_head.data;
                        div_dvs_in  = divisor;
                        div_rem_in  = '0;
                        div_step_in = 3'd7;
                        state_in    = ST_DIV;
                     end else if (out_free) begin
                        q_pop = 1'b1;
                     end
                  end
                  rxd_pkg::KIND_DATA: begin
                     if (out_free) begin
                        q_pop       = 1'b1;
                        phase_in    = phase_ff + 1'b1;
                        sum_in      = sum_next;
                        trail_in[0] = trail_ff[1];
                        trail_in[1] = trail_ff[2];
                        trail_in[2] = trail_ff[3];
                        trail_in[3] = plain;
                        count_in    = count_next;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase

               if (q_pop && q_head.last) begin
                  // final byte: report and start over with a fresh header
                  rsp_valid_in  = 1'b1;
                  rsp_last_in   = 1'b1;
                  if (q_head.kind != rxd_pkg::KIND_DATA) begin
                     rsp_byte_in   = '0;
                     rsp_status_in = rxd_pkg::STATUS_SHORT;
                  end else begin
                     rsp_byte_in = plain;
                     if (count_next < CNT_W'(TRAIL)) begin
                        rsp_status_in = rxd_pkg::STATUS_SHORT;
                     end else if (check == sum_next) begin
                        rsp_status_in = rxd_pkg::STATUS_OK;
                     end else begin
                        rsp_status_in = rxd_pkg::STATUS_MISMATCH;
                     end
                  end
                  rot_in    = '0;
                  window_in = '0;
                  phase_in  = '0;
                  sum_in    = '0;
                  count_in  = '0;
                  for (int i = 0; i < TRAIL; i++) begin
                     trail_in[i] = '0;
                  end
               end else if (q_pop && q_head.kind == rxd_pkg::KIND_DATA) begin
                  rsp_valid_in  = 1'b1;
                  rsp_last_in   = 1'b0;
                  rsp_byte_in   = plain;
                  rsp_status_in = rxd_pkg::STATUS_OK;
               end
            end
         end
         ST_DIV: begin
            div_rem_in  = rem_next;
            div_dvd_in  = {div_dvd_ff[6:0], 1'b0};
            div_step_in = div_step_ff - 1'b1;
            if (div_step_ff == '0) begin
               window_in = KIDX_W'(rem_next);
               state_in  = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      div_dvd_ff    <= div_dvd_in;
      div_dvs_ff    <= div_dvs_in;
      div_rem_ff    <= div_rem_in;
      div_step_ff   <= div_step_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= ST_RUN;
         rot_ff       <= '0;
         window_ff    <= '0;
         phase_ff     <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         key_len_ff   <= rxd_pkg::KEY_LEN_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TRAIL; i++) begin
            trail_ff[i] <= '0;
         end
         for (int b = 0; b < MAX_KEY_BYTES; b++) begin
            key_ff[b] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rot_ff       <= rot_in;
         window_ff    <= window_in;
         phase_ff     <= phase_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         key_len_ff   <= key_len_in;
         rsp_valid_ff <= rsp_valid_in;
         trail_ff     <= trail_in;
         key_ff       <= key_in;
      end
   end

endmodule

[rtl/rotate_xor_packet_descrambler_unit.sv]
// Rotate-XOR packet descrambler, top level. Instantiates rxd_front, rxd_queue and rxd_back.
// Depends on rxd_pkg.
//
// Each received byte enters a two-entry queue; the back end takes one byte per cycle, so
// payload bytes and the first header byte sustain one item per cycle while the response side
// accepts results. The second header byte holds the back end for its issue plus an 8-step
// remainder sequencer that derives the key window start; no byte is taken until it is done.
// One result per payload byte; a header byte yields a result only when it ends the packet.
// rsp_tdata carries the status field, meaningful on the item with rsp_tlast.
module rotate_xor_packet_descrambler_unit #(
   parameter int MAX_KEY_BYTES = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] cipher_byte
   input  logic                              req_tlast,   // last_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,   // [7:0] plain_byte, [9:8] status
   output logic                              rsp_tlast,   // end_of_packet
   input  logic                              csr_we,
   input  logic [rxd_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [rxd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic                 push;
   rxd_pkg::entry_type   push_entry;
   logic                 queue_full;
   logic                 q_pop;
   logic                 q_valid;
   rxd_pkg::entry_type   q_head;
   logic [7:0]           rsp_byte;
   rxd_pkg::status_type  rsp_status;

   rxd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   rxd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head       (q_head)
   );

   rxd_back #(
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_byte   (rsp_byte),
      .rsp_last   (rsp_tlast),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = {6'b0, rsp_status, rsp_byte};

   // back end only drains a queue that holds something
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   // status is only reported on the packet's final item
   a_status_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_status == rxd_pkg::STATUS_OK))
      else $error("status set on a non-final item");

   // a header byte that ends the packet is always reported as short with a zero byte
   a_short_header: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_head.last && q_head.kind != rxd_pkg::KIND_DATA) |=>
         (rsp_tvalid && rsp_tlast && rsp_byte == 8'd0 &&
          rsp_status == rxd_pkg::STATUS_SHORT))
      else $error("header-only packet not reported as short");

endmodule
